@@ hdl/tlph_pkg.sv @@
// Shared types and constants for the tank level percentage and alarm block.
package tlph_pkg;

  localparam int unsigned PctW      = 7;
  localparam int unsigned DivSteps  = PctW;
  localparam int unsigned StepCntW  = 3;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [PctW-1:0] PctFull  = PctW'(100);
  localparam logic [PctW-1:0] PctEmpty = '0;
  localparam int unsigned     Deadband = 5;

  localparam int unsigned EmptyReset = 300;
  localparam int unsigned FullReset  = 30;
  localparam logic [PctW-1:0] HighReset = PctW'(90);
  localparam logic [PctW-1:0] LowReset  = PctW'(10);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EMPTY = 2'd0,
    CFG_FULL  = 2'd1,
    CFG_HIGH  = 2'd2,
    CFG_LOW   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALARM_IN   = 2'd0,
    ALARM_LOW  = 2'd1,
    ALARM_HIGH = 2'd2
  } alarm_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCALE = 2'd1,
    ST_DIV   = 2'd2,
    ST_ALARM = 2'd3
  } state_e;

endpackage

@@ hdl/tank_level_percent_hysteresis.sv @@
// Top level: distance to fill percentage with a three-state hysteresis alarm.
//
// Usage:
//   Configuration transactions on cfg_* set empty distance (index 0), full
//   distance (1), high threshold (2) and low threshold (3); cfg_ready_o is
//   always high. Write only while the block is idle.
//   One distance transaction on in_* gives one result transaction on out_*
//   carrying level_percent, alarm_state and went_out.
//   Steps: ST_SCALE registers (empty - distance) * 100; a distance strictly
//   between full and empty then goes to ST_DIV, a restoring divider that
//   retires one quotient bit per cycle through a single subtractor, and
//   then to ST_ALARM; any other distance goes from ST_SCALE to ST_ALARM.
//   A new distance is accepted only after the previous result has been
//   loaded for output; in_ready_o is high only while the sequencer is idle.
//   Stall: a finished result waits in the output register; the next input
//   is accepted and computed meanwhile, and the sequencer holds in its last
//   step until the output register is free.
//   Reset: control and configuration registers take their reset values, the
//   datapath is not reset; alarm goes in range, no result is pending.
module tank_level_percent_hysteresis #(
  parameter int unsigned DISTANCE_WIDTH = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tlph_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [DISTANCE_WIDTH-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [DISTANCE_WIDTH-1:0]           distance_cm_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tlph_pkg::PctW-1:0]           level_percent_o,
  output logic [1:0]                          alarm_state_o,
  output logic                                went_out_o
);

  localparam int unsigned ProdW = DISTANCE_WIDTH + tlph_pkg::PctW;
  localparam int unsigned PctW  = tlph_pkg::PctW;

  tlph_pkg::state_e state_q, state_d;

  logic [DISTANCE_WIDTH-1:0] empty_q, full_q, dist_q;
  logic [PctW-1:0]           high_q, low_q, level_q;
  logic [ProdW-1:0]          rem_q, dsh_q;
  logic [tlph_pkg::StepCntW-1:0] cnt_q;
  tlph_pkg::alarm_e          alarm_q, alarm_d;
  logic                      went_d;
  logic                      out_valid_q;
  logic                      in_fire, out_load, div_last, needs_div;

  logic [DISTANCE_WIDTH-1:0] num, den;
  logic [ProdW-1:0]          prod;
  logic [ProdW:0]            diff;
  logic [PctW:0]             low_ret, level_ext, high_ext;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i & in_ready_o;
  assign div_last    = (cnt_q == tlph_pkg::StepCntW'(tlph_pkg::DivSteps - 1));
  assign needs_div   = (dist_q < empty_q) && (dist_q > full_q);

  assign num  = empty_q - dist_q;
  assign den  = empty_q - full_q;
  assign prod = ProdW'(num) * ProdW'(100);
  assign diff = {1'b0, rem_q} - {1'b0, dsh_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tlph_pkg::ST_IDLE:  if (in_fire) state_d = tlph_pkg::ST_SCALE;
      tlph_pkg::ST_SCALE: state_d = needs_div ? tlph_pkg::ST_DIV : tlph_pkg::ST_ALARM;
      tlph_pkg::ST_DIV:   if (div_last) state_d = tlph_pkg::ST_ALARM;
      tlph_pkg::ST_ALARM: if (out_load) state_d = tlph_pkg::ST_IDLE;
      default:            state_d = tlph_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      tlph_pkg::ST_IDLE:  in_ready_o = 1'b1;
      tlph_pkg::ST_ALARM: out_load   = ~out_valid_q | out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        out_load   = 1'b0;
      end
    endcase
  end

  // Alarm update
  assign level_ext = {1'b0, level_q};
  assign low_ret   = {1'b0, low_q} + (PctW + 1)'(tlph_pkg::Deadband);
  assign high_ext  = {1'b0, high_q};

  always_comb begin
    alarm_d = alarm_q;
    went_d  = 1'b0;
    case (alarm_q)
      tlph_pkg::ALARM_LOW: begin
        if (level_ext > low_ret) alarm_d = tlph_pkg::ALARM_IN;
      end
      tlph_pkg::ALARM_HIGH: begin
        if (level_ext + (PctW + 1)'(tlph_pkg::Deadband) < high_ext)
          alarm_d = tlph_pkg::ALARM_IN;
      end
      default: begin
        alarm_d = tlph_pkg::ALARM_IN;
        if (level_q >= high_q) begin
          alarm_d = tlph_pkg::ALARM_HIGH;
          went_d  = 1'b1;
        end else if (level_q <= low_q) begin
          alarm_d = tlph_pkg::ALARM_LOW;
          went_d  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlph_pkg::ST_IDLE;
      alarm_q     <= tlph_pkg::ALARM_IN;
      out_valid_q <= 1'b0;
      empty_q     <= DISTANCE_WIDTH'(tlph_pkg::EmptyReset);
      full_q      <= DISTANCE_WIDTH'(tlph_pkg::FullReset);
      high_q      <= tlph_pkg::HighReset;
      low_q       <= tlph_pkg::LowReset;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tlph_pkg::CFG_EMPTY: empty_q <= cfg_data_i;
          tlph_pkg::CFG_FULL:  full_q  <= cfg_data_i;
          tlph_pkg::CFG_HIGH:  high_q  <= cfg_data_i[PctW-1:0];
          tlph_pkg::CFG_LOW:   low_q   <= cfg_data_i[PctW-1:0];
          default:             empty_q <= empty_q;
        endcase
      end
      if (out_load) begin
        alarm_q     <= alarm_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == tlph_pkg::ST_SCALE) begin
        cnt_q <= '0;
      end else if (state_q == tlph_pkg::ST_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dist_q <= distance_cm_i;
    end
    if (state_q == tlph_pkg::ST_SCALE) begin
      rem_q   <= prod;
      dsh_q   <= ProdW'(den) << (PctW - 1);
      level_q <= (dist_q >= empty_q) ? tlph_pkg::PctEmpty : tlph_pkg::PctFull;
    end
    if (state_q == tlph_pkg::ST_DIV) begin
      if (!diff[ProdW]) begin
        rem_q <= diff[ProdW-1:0];
      end
      dsh_q   <= dsh_q >> 1;
      level_q <= (cnt_q == '0) ? PctW'(~diff[ProdW]) : {level_q[PctW-2:0], ~diff[ProdW]};
    end
    if (out_load) begin
      level_percent_o <= level_q;
      alarm_state_o   <= alarm_d;
      went_out_o      <= went_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/tlph_checker.sv @@
// Port-level checker for the tank level block, bound to the top level.
module tlph_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [tlph_pkg::PctW-1:0] level_percent_o,
  input logic [1:0]                alarm_state_o,
  input logic                      went_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(level_percent_o)
      && $stable(alarm_state_o) && $stable(went_out_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_percent_o <= tlph_pkg::PctFull)
    else $error("level above full");

  a_went_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && went_out_o |->
      alarm_state_o == tlph_pkg::ALARM_LOW || alarm_state_o == tlph_pkg::ALARM_HIGH)
    else $error("went_out without alarm");

endmodule

bind tank_level_percent_hysteresis tlph_checker u_tlph_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .level_percent_o (level_percent_o),
  .alarm_state_o   (alarm_state_o),
  .went_out_o      (went_out_o)
);
